// ----- rtl/core/two_phase_task_dispatcher_unit_defines.svh -----
// Assertion helpers for the task dispatcher.
// All checks are sampled on clk and are off while rst is high.
`ifndef TWO_PHASE_TASK_DISPATCHER_UNIT_DEFINES_SVH
`define TWO_PHASE_TASK_DISPATCHER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tpd_pkg.sv -----
package tpd_pkg;

  // Field and register widths
  localparam int MAP_CNT_W  = 7;
  localparam int RED_CNT_W  = 5;
  localparam int CFG_W      = 7;
  localparam int IDX_IN_W   = 6;
  localparam int TYPE_W     = 2;

  // Largest counts the registers can express
  localparam int MAP_CNT_MAX = 2 ** MAP_CNT_W - 1;
  localparam int RED_CNT_MAX = 2 ** RED_CNT_W - 1;

  // Free-task search is split into groups of this many entries
  localparam int GRP_SIZE = 16;
  localparam int LOC_W    = $clog2(GRP_SIZE);

  // Register indexes
  localparam logic REG_MAP_COUNT    = 1'b0;
  localparam logic REG_REDUCE_COUNT = 1'b1;

  // Request kinds
  localparam logic KIND_ASK    = 1'b0;
  localparam logic KIND_SUBMIT = 1'b1;

  // Task types on a submit
  localparam logic TT_MAP    = 1'b0;
  localparam logic TT_REDUCE = 1'b1;

  // Grant types
  localparam logic [TYPE_W-1:0] GT_NONE   = 2'd0;
  localparam logic [TYPE_W-1:0] GT_MAP    = 2'd1;
  localparam logic [TYPE_W-1:0] GT_REDUCE = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch request and first search stage
    logic commit;   // finish search, update state, load result
  } dp_cmd_t;

endpackage

// ----- rtl/core/tpd_ctrl.sv -----
module tpd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tpd_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_vld;

  // Handshake decode
  assign in_ready    = (state == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state == ST_EXEC) && (!out_vld || out_ready);
  assign out_valid   = out_vld;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and result-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      out_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_vld <= 1'b1;
      end else if (out_ready) begin
        out_vld <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/tpd_dp.sv -----
`include "two_phase_task_dispatcher_unit_defines.svh"

module tpd_dp #(
  parameter int MAX_MAP_TASKS    = 64,
  parameter int MAX_REDUCE_TASKS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tpd_pkg::dp_cmd_t               cmd,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [tpd_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_kind,
  input  logic                           in_type,
  input  logic [tpd_pkg::IDX_IN_W-1:0]   in_idx,
  output logic                           grant_valid,
  output logic [tpd_pkg::TYPE_W-1:0]     grant_type,
  output logic [tpd_pkg::IDX_IN_W-1:0]   grant_index,
  output logic                           submit_ok,
  output logic                           all_done
);

  // Only entries below the largest programmable count are reachable
  localparam int MAP_DEPTH = (MAX_MAP_TASKS < tpd_pkg::MAP_CNT_MAX) ?
                             MAX_MAP_TASKS : tpd_pkg::MAP_CNT_MAX;
  localparam int RED_DEPTH = (MAX_REDUCE_TASKS < tpd_pkg::RED_CNT_MAX) ?
                             MAX_REDUCE_TASKS : tpd_pkg::RED_CNT_MAX;
  localparam int SCAN_W    = (MAP_DEPTH > RED_DEPTH) ? MAP_DEPTH : RED_DEPTH;
  localparam int NGRP      = (SCAN_W + tpd_pkg::GRP_SIZE - 1) / tpd_pkg::GRP_SIZE;
  localparam int SCAN_PAD  = NGRP * tpd_pkg::GRP_SIZE;
  localparam int IDX_W     = $clog2(SCAN_PAD);
  localparam int MW        = tpd_pkg::MAP_CNT_W;
  localparam int RW        = tpd_pkg::RED_CNT_W;
  localparam int LW        = tpd_pkg::LOC_W;

  // Configuration
  logic [MW-1:0] map_cnt;
  logic [RW-1:0] red_cnt;

  // Task state
  logic [MAP_DEPTH-1:0] map_asg, map_done;
  logic [RED_DEPTH-1:0] red_asg, red_done;
  logic [MW-1:0]        map_total;
  logic [RW-1:0]        red_total;
  logic                 finished;

  // Latched request
  logic                         item_kind;
  logic                         item_type;
  logic [tpd_pkg::IDX_IN_W-1:0] item_idx;

  // First search stage, registered
  logic [NGRP-1:0]               grp_any;
  logic [LW-1:0]                 grp_loc [NGRP];
  logic [tpd_pkg::TYPE_W-1:0]    sc_type;

  // Combinational signals
  logic [MW-1:0]              nm;
  logic [RW-1:0]              nr;
  logic [SCAN_PAD-1:0]        scan_vec;
  logic [tpd_pkg::TYPE_W-1:0] scan_type;
  logic [NGRP-1:0]            grp_any_c;
  logic [LW-1:0]              grp_loc_c [NGRP];
  logic                       hit;
  logic [IDX_W-1:0]           gidx;
  logic                       grant;
  logic [MAP_DEPTH-1:0]       gdec_m, sdec_m;
  logic [RED_DEPTH-1:0]       gdec_r, sdec_r;
  logic                       is_sub, sub_map, sub_red;
  logic [MW-1:0]              map_total_next;
  logic [RW-1:0]              red_total_next;
  logic                       finished_next;

  // Totals clamped to the storage depth
  assign nm = (map_cnt > MW'(MAP_DEPTH)) ? MW'(MAP_DEPTH) : map_cnt;
  assign nr = (red_cnt > RW'(RED_DEPTH)) ? RW'(RED_DEPTH) : red_cnt;

  // Free vector of the current phase
  always_comb begin
    scan_vec  = '0;
    scan_type = tpd_pkg::GT_NONE;
    if (map_total < nm) begin
      scan_type = tpd_pkg::GT_MAP;
      for (int i = 0; i < MAP_DEPTH; i++) begin
        scan_vec[i] = !map_asg[i] && !map_done[i] && (i < int'(nm));
      end
    end else if (red_total < nr) begin
      scan_type = tpd_pkg::GT_REDUCE;
      for (int i = 0; i < RED_DEPTH; i++) begin
        scan_vec[i] = !red_asg[i] && !red_done[i] && (i < int'(nr));
      end
    end
  end

  // Per-group find-first
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_c[g] = |scan_vec[g*tpd_pkg::GRP_SIZE +: tpd_pkg::GRP_SIZE];
      grp_loc_c[g] = '0;
      for (int j = tpd_pkg::GRP_SIZE - 1; j >= 0; j--) begin
        if (scan_vec[g*tpd_pkg::GRP_SIZE + j]) grp_loc_c[g] = LW'(j);
      end
    end
  end

  // Across-group find-first
  always_comb begin
    hit  = 1'b0;
    gidx = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        hit  = 1'b1;
        gidx = IDX_W'(g * tpd_pkg::GRP_SIZE + int'(grp_loc[g]));
      end
    end
  end

  assign grant  = (item_kind == tpd_pkg::KIND_ASK) && hit;
  assign is_sub = (item_kind == tpd_pkg::KIND_SUBMIT);

  // One-hot decodes of grant and submit positions
  always_comb begin
    for (int i = 0; i < MAP_DEPTH; i++) begin
      gdec_m[i] = (int'(gidx) == i);
      sdec_m[i] = (int'(item_idx) == i);
    end
    for (int i = 0; i < RED_DEPTH; i++) begin
      gdec_r[i] = (int'(gidx) == i);
      sdec_r[i] = (int'(item_idx) == i);
    end
  end

  // Submit checks: in range and not already done
  assign sub_map = is_sub && (item_type == tpd_pkg::TT_MAP) &&
                   (MW'(item_idx) < nm) && !(|(map_done & sdec_m));
  assign sub_red = is_sub && (item_type == tpd_pkg::TT_REDUCE) &&
                   (item_idx < tpd_pkg::IDX_IN_W'(nr)) && !(|(red_done & sdec_r));

  assign map_total_next = map_total + MW'(sub_map);
  assign red_total_next = red_total + RW'(sub_red);
  assign finished_next  = finished ||
                          (is_sub && (map_total_next >= nm) && (red_total_next >= nr));

  // Configuration, task state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      map_cnt   <= '0;
      red_cnt   <= '0;
      map_asg   <= '0;
      map_done  <= '0;
      red_asg   <= '0;
      red_done  <= '0;
      map_total <= '0;
      red_total <= '0;
      finished  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          tpd_pkg::REG_MAP_COUNT:    map_cnt <= cfg_wdata[MW-1:0];
          tpd_pkg::REG_REDUCE_COUNT: red_cnt <= cfg_wdata[RW-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        if (grant && (sc_type == tpd_pkg::GT_MAP))    map_asg <= map_asg | gdec_m;
        if (grant && (sc_type == tpd_pkg::GT_REDUCE)) red_asg <= red_asg | gdec_r;
        if (sub_map) begin
          map_done <= map_done | sdec_m;
          map_asg  <= map_asg & ~sdec_m;
        end
        if (sub_red) begin
          red_done <= red_done | sdec_r;
          red_asg  <= red_asg & ~sdec_r;
        end
        map_total <= map_total_next;
        red_total <= red_total_next;
        finished  <= finished_next;
      end
    end
  end

  // Request latch and first search stage
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_kind <= in_kind;
      item_type <= in_type;
      item_idx  <= in_idx;
      grp_any   <= grp_any_c;
      grp_loc   <= grp_loc_c;
      sc_type   <= scan_type;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      grant_valid <= grant;
      grant_type  <= grant ? sc_type : tpd_pkg::GT_NONE;
      grant_index <= grant ? tpd_pkg::IDX_IN_W'(gidx) : '0;
      submit_ok   <= sub_map || sub_red;
      all_done    <= finished_next;
    end
  end

  `TPD_ASSERT_NXT(a_finished_sticky, finished, finished, "finished flag dropped")
  `TPD_ASSERT_NOW(a_map_total, 1'b1, $countones(map_done) == int'(map_total), "map count off")
  `TPD_ASSERT_NOW(a_red_total, 1'b1, $countones(red_done) == int'(red_total), "reduce count off")
  `TPD_ASSERT_NOW(a_map_excl, 1'b1, (map_asg & map_done) == '0, "map task assigned and done")
  `TPD_ASSERT_NOW(a_red_excl, 1'b1, (red_asg & red_done) == '0, "reduce task assigned and done")

endmodule

// ----- rtl/core/two_phase_task_dispatcher_unit.sv -----
// On accept a request is latched with the first search stage; its result is then loaded
// into the result register for m_axis, held back while an earlier result still waits there.
// A request is taken only once the last has committed; the free-task search is a two-stage
// tree (groups of 16 entries registered at accept, then across groups) feeding the update.
// The result register lets the next request in while a result waits downstream.
// Reset (synchronous): task bits, counts and flags clear; request and result data do not.
module two_phase_task_dispatcher_unit #(
  parameter int MAX_MAP_TASKS    = 64,
  parameter int MAX_REDUCE_TASKS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write port
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [tpd_pkg::CFG_W-1:0] cfg_wdata,
  // Request stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [5:0] task_index
  input  logic [1:0]                s_axis_tuser,  // [0] kind, [1] task_type
  // Result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata   // [0] grant_valid, [2:1] grant_type,
                                                   // [8:3] grant_index, [9] submit_ok,
                                                   // [10] all_done
);

  tpd_pkg::dp_cmd_t                  cmd;
  logic                              grant_valid;
  logic [tpd_pkg::TYPE_W-1:0]        grant_type;
  logic [tpd_pkg::IDX_IN_W-1:0]      grant_index;
  logic                              submit_ok;
  logic                              all_done;

  tpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  tpd_dp #(
    .MAX_MAP_TASKS    (MAX_MAP_TASKS),
    .MAX_REDUCE_TASKS (MAX_REDUCE_TASKS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_kind     (s_axis_tuser[0]),
    .in_type     (s_axis_tuser[1]),
    .in_idx      (s_axis_tdata[5:0]),
    .grant_valid (grant_valid),
    .grant_type  (grant_type),
    .grant_index (grant_index),
    .submit_ok   (submit_ok),
    .all_done    (all_done)
  );

  // Pack result fields, zero fill to 16 bits
  assign m_axis_tdata = {5'b0, all_done, submit_ok, grant_index, grant_type, grant_valid};

endmodule
